// ===== sv/lruchc_pkg.sv =====
package lruchc_pkg;

    // fixed widths of the block's ports
    localparam int PAGE_PORT_W = 32;
    localparam int CFG_W       = 11;
    localparam int CNT_W       = 32;

    // saturation value of both running counters
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // control flags of one access travelling along the chain
    typedef struct packed {
        logic valid;    // an access sits on this link
        logic active;   // still looking for its place in the stack
        logic hit;      // page was found resident
        logic evicted;  // least recent page was pushed out
    } t_tok;

endpackage

// ===== sv/lruchc_cell.sv =====
module lruchc_cell
    import lruchc_pkg::*;
#(
    parameter int PAGE_BITS = 32,
    parameter int CAP_W     = 11,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [CAP_W-1:0]     i_cap,
    input  t_tok                 i_tok,
    input  logic [PAGE_BITS-1:0] i_key,
    input  logic [PAGE_BITS-1:0] i_carry,
    input  logic                 i_next_valid,
    output logic                 o_valid,
    output t_tok                 o_tok,
    output logic [PAGE_BITS-1:0] o_key,
    output logic [PAGE_BITS-1:0] o_carry
);

    // number of slots up to and including this one
    localparam logic [CAP_W-1:0] POS = CAP_W'(IDX + 1);

    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_page;
    t_tok                 r_tok;
    logic [PAGE_BITS-1:0] r_key;
    logic [PAGE_BITS-1:0] r_carry;

    logic                 n_valid;
    logic [PAGE_BITS-1:0] n_page;
    t_tok                 n_tok;
    logic [PAGE_BITS-1:0] n_carry;

    logic act;
    logic match;
    logic next_live;
    logic last;
    logic full;

    // an active access one slot further down is about to fill that slot
    assign next_live = i_next_valid || (r_tok.valid && r_tok.active);
    assign act       = i_tok.valid && i_tok.active;
    assign match     = r_valid && (r_page == i_key);
    assign last      = r_valid && !next_live;
    assign full      = (POS >= i_cap);

    // compare, swap with the carried page, or settle the access here
    always_comb begin
        n_valid = r_valid;
        n_page  = r_page;
        n_tok   = i_tok;
        n_carry = i_carry;
        if (act) begin
            n_page = i_carry;
            if (!r_valid) begin
                // first empty slot: stack grows by one
                n_valid      = 1'b1;
                n_tok.active = 1'b0;
                n_carry      = '0;
            end else if (match) begin
                n_tok.active = 1'b0;
                n_tok.hit    = 1'b1;
                n_carry      = '0;
            end else if (last && full) begin
                // bottom of a full stack: old page leaves with the beat
                n_tok.active  = 1'b0;
                n_tok.evicted = 1'b1;
                n_carry       = r_page;
            end else begin
                n_carry = r_page;
            end
        end
    end

    // slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_page <= n_page;
        end
    end

    // link register towards the next slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key   <= i_key;
            r_carry <= n_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_key   = r_key;
    assign o_carry = r_carry;

endmodule

// ===== sv/lru_cache_hit_counter.sv =====
// Fully associative page cache with least recently used replacement, built as a
// recency stack of MAX_SLOTS slots, most recent at slot 0. Every accepted page
// beat walks down the stack one slot per cycle, swapping with each slot it
// passes until it finds its own page (hit), the first empty slot (insert) or
// the bottom of a full stack (eviction); it then rides on to the end of the
// chain with its result. A new beat can be taken every cycle unless the output
// is stalled, and a stalled output freezes the whole chain; each result passes
// through every slot's link register and the output register. slots_in_use is
// clamped to 1..MAX_SLOTS and should be written only while no beat is in
// flight. Slot valid bits clear at reset, so there is no clearing pass.
module lru_cache_hit_counter
    import lruchc_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    parameter int PAGE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_slots_in_use,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [PAGE_PORT_W-1:0] i_page_number,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_hit,
    output logic                   o_evicted,
    output logic [PAGE_PORT_W-1:0] o_evicted_page,
    output logic [CNT_W-1:0]       o_hit_count,
    output logic [CNT_W-1:0]       o_access_count
);

    localparam int CAP_W = $clog2(MAX_SLOTS + 1);
    localparam logic [CAP_W-1:0] CAP_RESET =
        CAP_W'((1024 > MAX_SLOTS) ? MAX_SLOTS : 1024);

    logic [CAP_W-1:0]       r_cap;
    logic [CAP_W-1:0]       n_cap;
    logic                   r_out_valid;
    logic                   r_hit;
    logic                   r_evicted;
    logic [PAGE_PORT_W-1:0] r_ev_page;
    logic [CNT_W-1:0]       r_hits;
    logic [CNT_W-1:0]       r_acc;

    logic                   adv;
    logic [PAGE_BITS-1:0]   key_in;
    logic [PAGE_PORT_W-1:0] tail_page;

    t_tok                   w_tok   [MAX_SLOTS+1];
    logic [PAGE_BITS-1:0]   w_key   [MAX_SLOTS+1];
    logic [PAGE_BITS-1:0]   w_carry [MAX_SLOTS+1];
    logic [MAX_SLOTS:0]     w_slot_valid;

    // whole chain moves when the output register is free or being emptied
    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !adv;
    assign o_cfg_ready = 1'b1;

    // page width adaption on the way in and out
    generate
        if (PAGE_BITS > PAGE_PORT_W) begin : g_wide
            assign key_in    = {{(PAGE_BITS - PAGE_PORT_W){1'b0}}, i_page_number};
            assign tail_page = w_carry[MAX_SLOTS][PAGE_PORT_W-1:0];
        end else if (PAGE_BITS == PAGE_PORT_W) begin : g_equal
            assign key_in    = i_page_number;
            assign tail_page = w_carry[MAX_SLOTS];
        end else begin : g_narrow
            assign key_in    = i_page_number[PAGE_BITS-1:0];
            assign tail_page = {{(PAGE_PORT_W - PAGE_BITS){1'b0}}, w_carry[MAX_SLOTS]};
        end
    endgenerate

    // beat entering the top of the stack
    assign w_tok[0]   = t_tok'{valid: i_in_valid, active: 1'b1, default: 1'b0};
    assign w_key[0]   = key_in;
    assign w_carry[0] = key_in;

    assign w_slot_valid[MAX_SLOTS] = 1'b0;

    // recency stack
    generate
        for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_slot
            lruchc_cell #(
                .PAGE_BITS (PAGE_BITS),
                .CAP_W     (CAP_W),
                .IDX       (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_adv        (adv),
                .i_cap        (r_cap),
                .i_tok        (w_tok[g]),
                .i_key        (w_key[g]),
                .i_carry      (w_carry[g]),
                .i_next_valid (w_slot_valid[g+1]),
                .o_valid      (w_slot_valid[g]),
                .o_tok        (w_tok[g+1]),
                .o_key        (w_key[g+1]),
                .o_carry      (w_carry[g+1])
            );
        end
    endgenerate

    // capacity clamp on write
    always_comb begin
        if (i_cfg_slots_in_use == '0) begin
            n_cap = CAP_W'(1);
        end else if (32'(i_cfg_slots_in_use) > 32'(MAX_SLOTS)) begin
            n_cap = CAP_W'(MAX_SLOTS);
        end else begin
            n_cap = CAP_W'(i_cfg_slots_in_use);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= n_cap;
        end
    end

    // output register and saturating counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_acc       <= '0;
        end else if (adv) begin
            r_out_valid <= w_tok[MAX_SLOTS].valid;
            if (w_tok[MAX_SLOTS].valid) begin
                if (w_tok[MAX_SLOTS].hit && (r_hits != CNT_MAX)) begin
                    r_hits <= r_hits + CNT_W'(1);
                end
                if (r_acc != CNT_MAX) begin
                    r_acc <= r_acc + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && w_tok[MAX_SLOTS].valid) begin
            r_hit     <= w_tok[MAX_SLOTS].hit;
            r_evicted <= w_tok[MAX_SLOTS].evicted;
            r_ev_page <= tail_page;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_ev_page;
    assign o_hit_count    = r_hits;
    assign o_access_count = r_acc;

`ifndef ASSERT_OFF
    // a beat settles one way only
    a_hit_xor_evict : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction reported together");

    // no stale page leaks out when nothing was evicted
    a_ev_page_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted) |-> (o_evicted_page == '0))
        else $error("evicted page not zero without eviction");

    // hits never outrun accesses
    a_hits_le_acc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hit_count <= o_access_count))
        else $error("hit count above access count");

    // clamped capacity stays in range
    a_cap_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cap != '0) && (32'(r_cap) <= 32'(MAX_SLOTS)))
        else $error("capacity out of range");
`endif

endmodule

// ===== bench/lru_access_checker.sv =====
`timescale 1ns / 100ps

module lru_access_checker
    import lruchc_pkg::*;
#(
    parameter int NUM_SLOTS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_slots_in_use,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [PAGE_PORT_W-1:0] i_page_number,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_hit,
    input  logic                   i_evicted,
    input  logic [PAGE_PORT_W-1:0] i_evicted_page,
    input  logic [CNT_W-1:0]       i_hit_count,
    input  logic [CNT_W-1:0]       i_access_count,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam logic [CFG_W-1:0] SLOTS_AT_RESET = 11'd1024;

    typedef struct packed {
        logic                   hit;
        logic                   evicted;
        logic [PAGE_PORT_W-1:0] evicted_page;
        logic [CNT_W-1:0]       hit_count;
        logic [CNT_W-1:0]       access_count;
    } t_access_result;

    // recency stack: entry 0 least recent, entry resident_cnt-1 most recent
    logic [PAGE_PORT_W-1:0] recency [NUM_SLOTS];
    int unsigned            resident_cnt;
    logic [CNT_W-1:0]       hits_seen;
    logic [CNT_W-1:0]       accesses_seen;
    logic [CFG_W-1:0]       slots_reg;
    t_access_result         awaited_results [$];
    int                     mismatch_cnt;

    // close the gap and place the page at the most recent end
    function automatic void lift_to_top(input int unsigned gap_pos,
                                        input logic [PAGE_PORT_W-1:0] page);
        for (int unsigned k = gap_pos; k + 1 < resident_cnt; k++)
            recency[k] = recency[k + 1];
        recency[resident_cnt - 1] = page;
    endfunction

    // look one page up, update the stack and counters, give the result beat
    function automatic t_access_result predict_access(input logic [PAGE_PORT_W-1:0] page);
        int unsigned    cap;
        int unsigned    pos;
        bit             found;
        t_access_result res;
        cap = 32'(slots_reg);
        if (cap < 1)
            cap = 1;
        if (cap > NUM_SLOTS)
            cap = NUM_SLOTS;
        found = 1'b0;
        pos = 0;
        for (int unsigned k = 0; k < resident_cnt && !found; k++) begin
            if (recency[k] == page) begin
                found = 1'b1;
                pos = k;
            end
        end
        res = '0;
        if (found) begin
            res.hit = 1'b1;
            lift_to_top(pos, page);
            if (hits_seen != CNT_MAX)
                hits_seen++;
        end else if (resident_cnt >= cap) begin
            // full, or capacity lowered under the occupancy: drop the oldest only
            res.evicted = 1'b1;
            res.evicted_page = recency[0];
            lift_to_top(0, page);
        end else begin
            recency[resident_cnt] = page;
            resident_cnt++;
        end
        if (accesses_seen != CNT_MAX)
            accesses_seen++;
        res.hit_count = hits_seen;
        res.access_count = accesses_seen;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // watch all three channels at each rising edge
    always @(posedge i_clk) begin : watch
        t_access_result want;
        if (!i_rst_n) begin
            resident_cnt = 0;
            hits_seen = '0;
            accesses_seen = '0;
            slots_reg = SLOTS_AT_RESET;
            awaited_results.delete();
            mismatch_cnt = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                slots_reg = i_cfg_slots_in_use;
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(predict_access(i_page_number));
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with no access waiting for it");
                    mismatch_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("hit", CNT_W'(want.hit), CNT_W'(i_hit));
                    check_field("evicted", CNT_W'(want.evicted), CNT_W'(i_evicted));
                    check_field("evicted_page", want.evicted_page, i_evicted_page);
                    check_field("hit_count", want.hit_count, i_hit_count);
                    check_field("access_count", want.access_count, i_access_count);
                end
            end
        end
        o_fail_count <= mismatch_cnt;
        o_pending <= awaited_results.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import lruchc_pkg::*;

    localparam int MAX_SLOTS    = 1024;
    localparam int POOL_MAX     = 128;
    localparam int RECENT_DEPTH = 64;
    localparam int SMALL_BEATS  = 40;
    localparam int STREAM_BEATS = 1200;
    localparam int STREAM_PAUSE = 300;
    localparam int MODE1_AT     = 450;
    localparam int MODE2_AT     = 800;
    localparam int HOLD_AT      = 950;
    localparam int HOLD_CYCLES  = 1500;
    localparam int TAIL_CYCLES  = MAX_SLOTS + 100;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_slots_in_use;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [PAGE_PORT_W-1:0] i_page_number;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_hit;
    logic                   o_evicted;
    logic [PAGE_PORT_W-1:0] o_evicted_page;
    logic [CNT_W-1:0]       o_hit_count;
    logic [CNT_W-1:0]       o_access_count;

    int   fail_count;
    int   pending;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   beats_sent;
    logic hold_armed;
    bit   hold_done;

    lru_cache_hit_counter #(
        .MAX_SLOTS (MAX_SLOTS)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_slots_in_use (i_cfg_slots_in_use),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_page_number      (i_page_number),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_evicted          (o_evicted),
        .o_evicted_page     (o_evicted_page),
        .o_hit_count        (o_hit_count),
        .o_access_count     (o_access_count)
    );

    lru_access_checker #(
        .NUM_SLOTS (MAX_SLOTS)
    ) i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_slots_in_use (i_cfg_slots_in_use),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_page_number      (i_page_number),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_hit              (o_hit),
        .i_evicted          (o_evicted),
        .i_evicted_page     (o_evicted_page),
        .i_hit_count        (o_hit_count),
        .i_access_count     (o_access_count),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall, plus one long hold-off once armed
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
            end
        end
    end

    // offer one page beat, with random gaps in front of it
    task automatic send_page(input logic [PAGE_PORT_W-1:0] page);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
        // idling pattern moves on with the beat count
        if (beats_sent == MODE1_AT) begin
            sender_idle_pct = 79;
            receiver_idle_pct = 29;
        end
        if (beats_sent == MODE2_AT) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
        end
        if (beats_sent == HOLD_AT)
            hold_armed <= 1'b1;
    endtask

    // stop sending and wait until every result beat has come back
    task automatic settle_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_slots(input logic [CFG_W-1:0] slots);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_slots_in_use <= slots;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // random pages drawn mostly from a pool sized around the capacity
    task automatic run_pool_phase(input logic [CFG_W-1:0] slots);
        logic [PAGE_PORT_W-1:0] pool [POOL_MAX];
        int                     pool_size;
        write_slots(slots);
        pool_size = slots + slots / 2 + 2;
        if (pool_size > POOL_MAX)
            pool_size = POOL_MAX;
        foreach (pool[k])
            pool[k] = $urandom();
        repeat (SMALL_BEATS) begin
            if ($urandom_range(0, 99) < 85)
                send_page(pool[$urandom_range(0, pool_size - 1)]);
            else
                send_page($urandom());
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        logic [PAGE_PORT_W-1:0] pg;
        logic [PAGE_PORT_W-1:0] recent [RECENT_DEPTH];
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_page_number <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_slots_in_use <= '0;
        hold_armed <= 1'b0;
        sender_idle_pct = 29;
        receiver_idle_pct = 79;
        beats_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero capacity acts as one slot: insert, hit, evict
        write_slots(11'd0);
        send_page(32'h0000_0000);
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
        send_page(32'hFFFF_FFFF);
        send_page(32'hAAAA_AAAA);

        // two slots: hit reorders, so the other page goes next
        write_slots(11'd2);
        send_page(32'h5555_5555);
        send_page(32'hAAAA_AAAA);
        send_page(32'h0000_0001);
        send_page(32'h5555_5555);

        // capacity above the built size clamps to it
        write_slots(11'd2047);
        send_page(32'h8000_0000);
        send_page(32'h7FFF_FFFF);
        send_page(32'h0000_0001);
        send_page(32'hFFFF_FFFE);

        // capacity dropped under occupancy: residents hit, misses drop one
        write_slots(11'd1);
        send_page(32'h7FFF_FFFF);
        send_page(32'h0000_FFFF);
        send_page(32'h5555_5555);

        // random phases over small capacities, raised and lowered
        run_pool_phase(11'd7);
        run_pool_phase(11'd16);
        run_pool_phase(11'd3);
        run_pool_phase(11'd40);
        run_pool_phase(11'd0);
        run_pool_phase(11'd64);

        // full capacity: mostly fresh pages to fill the stack, some reuse
        write_slots(CFG_W'(MAX_SLOTS));
        foreach (recent[k])
            recent[k] = '0;
        for (int n = 0; n < STREAM_BEATS; n++) begin
            if (n == STREAM_PAUSE)
                settle_block();
            if ($urandom_range(0, 99) < 12)
                pg = recent[$urandom_range(0, RECENT_DEPTH - 1)];
            else
                pg = $urandom();
            recent[n % RECENT_DEPTH] = pg;
            send_page(pg);
        end

        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lruchc_pkg.sv
sv/lruchc_cell.sv
sv/lru_cache_hit_counter.sv
bench/lru_access_checker.sv
bench/tb.sv
